/* rtl/tlpr_pkg.sv */
`default_nettype none
// Shared types and constants for the two-list page replacer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package tlpr_pkg;

	localparam int FRAME_W = 6;
	localparam int COUNT_W = 7;
	localparam int KIND_W  = 2;

	typedef logic [KIND_W-1:0]  kind_raw_t;
	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [COUNT_W-1:0] count_t;

	// Request codes. The fourth code is unused and leaves the state alone.
	typedef enum logic [KIND_W-1:0] {
		KIND_VICTIM = 2'd0,
		KIND_PIN    = 2'd1,
		KIND_UNPIN  = 2'd2
	} kind_t;

endpackage
`default_nettype wire

/* rtl/tlpr_req_if.sv */
`default_nettype none
// Request channel of the page replacer: valid/ready handshake with kind and frame.
// Depends on tlpr_pkg for the field types.
interface tlpr_req_if;
	logic               valid;
	logic               ready;
	tlpr_pkg::kind_raw_t kind;
	tlpr_pkg::frame_t    frame;

	modport source (output valid, output kind, output frame, input ready);
	modport sink   (input valid, input kind, input frame, output ready);
endinterface
`default_nettype wire

/* rtl/tlpr_rsp_if.sv */
`default_nettype none
// Result channel of the page replacer: valid/ready handshake with the victim report.
// Depends on tlpr_pkg for the field types.
interface tlpr_rsp_if;
	logic             valid;
	logic             ready;
	logic             victim_found;
	tlpr_pkg::frame_t victim_frame;
	tlpr_pkg::count_t evictable_count;

	modport source (output valid, output victim_found, output victim_frame,
		output evictable_count, input ready);
	modport sink   (input valid, input victim_found, input victim_frame,
		input evictable_count, output ready);
endinterface
`default_nettype wire

/* rtl/two_list_page_replacer_unit.sv */
`default_nettype none
// Two-list page replacer: one request item per cycle, unless a result not yet taken stalls stage 1.
// An accepted item is held in stage 1 with its links, which are read at the accept edge (with
// write-first bypass); the lists and marks are updated as it leaves stage 1 for the result register,
// which holds the answer until taken. Each link memory has a single write port.
// Reset clears the list membership bits, seen marks, heads, tails and counts at once;
// the link memories are not cleared, since a link is always written before its value is used.
// Depends on tlpr_pkg, tlpr_req_if and tlpr_rsp_if.
module two_list_page_replacer_unit #(
	parameter int NUM_FRAMES = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	tlpr_req_if.sink    req,
	tlpr_rsp_if.source  rsp
);

	localparam int IW = $clog2(NUM_FRAMES);
	localparam int CW = $clog2(NUM_FRAMES + 1);

	typedef logic [IW-1:0] idx_t;
	typedef logic [CW-1:0] cnt_t;

	// List link memories.
	idx_t next_mem [NUM_FRAMES];
	idx_t prev_mem [NUM_FRAMES];

	// Stage 1 holds the accepted item and the links read for it.
	logic                valid_s1;
	tlpr_pkg::kind_raw_t kind_s1;
	tlpr_pkg::frame_t    frame_s1;
	idx_t                rp_s1;
	idx_t                rn_s1;

	logic [NUM_FRAMES-1:0] in_cold_q, in_hot_q, seen_q;
	logic [NUM_FRAMES-1:0] in_cold_d, in_hot_d, seen_d;
	idx_t cold_head_q, cold_tail_q, hot_head_q, hot_tail_q;
	idx_t cold_head_d, cold_tail_d, hot_head_d, hot_tail_d;
	cnt_t cold_count_q, hot_count_q, cold_count_d, hot_count_d;

	logic             rsp_valid_q;
	logic             found_q;
	tlpr_pkg::frame_t frame_q;
	tlpr_pkg::count_t count_q;

	logic adv_s1, acc;

	// Per-item control decoded in stage 1.
	logic do_link, do_unlink, use_hot, clr_seen, found;
	idx_t node, fi, l_head, l_tail, n_head, n_tail;
	cnt_t l_count, n_count;
	logic f_ok, node_ok;

	logic nw_en, pw_en;
	idx_t nw_addr, nw_data, pw_addr, pw_data;
	idx_t rd_addr, vt_d;

	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign acc       = req.valid && req.ready;

	assign fi      = idx_t'(frame_s1);
	assign f_ok    = 32'(frame_s1) < NUM_FRAMES;
	assign node_ok = 32'(node) < NUM_FRAMES;

	always_comb begin
		do_link   = 1'b0;
		do_unlink = 1'b0;
		use_hot   = 1'b0;
		clr_seen  = 1'b0;
		found     = 1'b0;
		node      = fi;
		if (adv_s1) begin
			case (kind_s1)
				tlpr_pkg::KIND_VICTIM: begin
					if (cold_count_q != '0) begin
						do_unlink = 1'b1;
						node      = cold_tail_q;
						clr_seen  = 1'b1;
						found     = 1'b1;
					end else if (hot_count_q != '0) begin
						do_unlink = 1'b1;
						use_hot   = 1'b1;
						node      = hot_tail_q;
						clr_seen  = 1'b1;
						found     = 1'b1;
					end
				end
				tlpr_pkg::KIND_PIN: begin
					if (f_ok && in_cold_q[fi]) begin
						do_unlink = 1'b1;
					end else if (f_ok && in_hot_q[fi]) begin
						do_unlink = 1'b1;
						use_hot   = 1'b1;
					end
				end
				tlpr_pkg::KIND_UNPIN: begin
					if (f_ok && !in_cold_q[fi] && !in_hot_q[fi]) begin
						do_link = 1'b1;
						use_hot = seen_q[fi];
					end
				end
				default: ;
			endcase
		end
	end

	// Head, tail and count of the list that the item works on, and the link writes.
	always_comb begin
		l_head  = use_hot ? hot_head_q : cold_head_q;
		l_tail  = use_hot ? hot_tail_q : cold_tail_q;
		l_count = use_hot ? hot_count_q : cold_count_q;
		n_head  = l_head;
		n_tail  = l_tail;
		n_count = l_count;
		nw_en   = 1'b0;
		nw_addr = node;
		nw_data = l_head;
		pw_en   = 1'b0;
		pw_addr = l_head;
		pw_data = node;
		if (do_link) begin
			n_count = l_count + cnt_t'(1);
			if (l_count == '0) begin
				n_head = node;
				n_tail = node;
			end else begin
				nw_en  = 1'b1;
				pw_en  = 1'b1;
				n_head = node;
			end
		end else if (do_unlink && l_count != '0) begin
			n_count = l_count - cnt_t'(1);
			if (l_count == cnt_t'(1)) begin
				n_head = '0;
				n_tail = '0;
			end else if (node == l_head) begin
				n_head = rn_s1;
			end else if (node == l_tail) begin
				n_tail = rp_s1;
			end else if (32'(rp_s1) < NUM_FRAMES && 32'(rn_s1) < NUM_FRAMES) begin
				// Middle node: splice its neighbors together.
				nw_en   = 1'b1;
				nw_addr = rp_s1;
				nw_data = rn_s1;
				pw_en   = 1'b1;
				pw_addr = rn_s1;
				pw_data = rp_s1;
			end
		end
	end

	always_comb begin
		cold_head_d  = cold_head_q;
		cold_tail_d  = cold_tail_q;
		cold_count_d = cold_count_q;
		hot_head_d   = hot_head_q;
		hot_tail_d   = hot_tail_q;
		hot_count_d  = hot_count_q;
		in_cold_d    = in_cold_q;
		in_hot_d     = in_hot_q;
		seen_d       = seen_q;
		if (do_link || do_unlink) begin
			if (use_hot) begin
				hot_head_d  = n_head;
				hot_tail_d  = n_tail;
				hot_count_d = n_count;
			end else begin
				cold_head_d  = n_head;
				cold_tail_d  = n_tail;
				cold_count_d = n_count;
			end
		end
		if (node_ok) begin
			if (do_link) begin
				seen_d[node] = 1'b1;
				if (use_hot) begin
					in_hot_d[node] = 1'b1;
				end else begin
					in_cold_d[node] = 1'b1;
				end
			end else if (do_unlink) begin
				if (clr_seen) begin
					seen_d[node] = 1'b0;
				end
				if (use_hot) begin
					in_hot_d[node] = 1'b0;
				end else begin
					in_cold_d[node] = 1'b0;
				end
			end
		end
	end

	// The next item reads its links against the state left by the item now in stage 1.
	assign vt_d    = (cold_count_d != '0) ? cold_tail_d : hot_tail_d;
	assign rd_addr = (req.kind == tlpr_pkg::KIND_VICTIM) ? vt_d : idx_t'(req.frame);

	always_ff @(posedge clk) begin
		if (nw_en) begin
			next_mem[nw_addr] <= nw_data;
		end
		if (pw_en) begin
			prev_mem[pw_addr] <= pw_data;
		end
		if (acc) begin
			rn_s1 <= (nw_en && nw_addr == rd_addr) ? nw_data : next_mem[rd_addr];
			rp_s1 <= (pw_en && pw_addr == rd_addr) ? pw_data : prev_mem[rd_addr];
			kind_s1  <= req.kind;
			frame_s1 <= req.frame;
		end
		if (adv_s1) begin
			found_q <= found;
			frame_q <= found ? tlpr_pkg::frame_t'(node) : '0;
			count_q <= tlpr_pkg::count_t'(cold_count_d + hot_count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			in_cold_q    <= '0;
			in_hot_q     <= '0;
			seen_q       <= '0;
			cold_head_q  <= '0;
			cold_tail_q  <= '0;
			hot_head_q   <= '0;
			hot_tail_q   <= '0;
			cold_count_q <= '0;
			hot_count_q  <= '0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			in_cold_q    <= in_cold_d;
			in_hot_q     <= in_hot_d;
			seen_q       <= seen_d;
			cold_head_q  <= cold_head_d;
			cold_tail_q  <= cold_tail_d;
			hot_head_q   <= hot_head_d;
			hot_tail_q   <= hot_tail_d;
			cold_count_q <= cold_count_d;
			hot_count_q  <= hot_count_d;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.victim_found    = found_q;
	assign rsp.victim_frame    = frame_q;
	assign rsp.evictable_count = count_q;

endmodule
`default_nettype wire
